FILE: sv/hdep_pkg.sv
// ----------------------------------------------------------------------------
// HTTP date parser package
// Shared types, name tables and calendar constants for the HTTP date parser.
// ----------------------------------------------------------------------------
package hdep_pkg;

   // Parse position within the date text.
   typedef enum logic [4:0] {
      PH_WDAY,
      PH_COMMA,
      PH_SPACE,
      PH_DAY1,
      PH_DAY2,
      PH_DAYSEP,
      PH_MON,
      PH_MONSEP,
      PH_YEAR,
      PH_H1,
      PH_H2,
      PH_C1,
      PH_M1,
      PH_M2,
      PH_C2,
      PH_S1,
      PH_S2,
      PH_SP,
      PH_G,
      PH_GM,
      PH_GMT,
      PH_DONE
   } phase_type;

   localparam int WD_COUNT = 7;
   localparam int MO_COUNT = 12;

   // Weekday names, padded with spaces to the longest name.
   localparam logic [8*9-1:0] WD_NAME [WD_COUNT] = '{
      "sunday   ", "monday   ", "tuesday  ", "wednesday",
      "thursday ", "friday   ", "saturday "
   };
   localparam logic [3:0] WD_LEN [WD_COUNT] = '{
      4'd6, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8
   };

   // Three-letter month names.
   localparam logic [8*3-1:0] MO_NAME [MO_COUNT] = '{
      "jan", "feb", "mar", "apr", "may", "jun",
      "jul", "aug", "sep", "oct", "nov", "dec"
   };
   localparam logic [6:0] MO_DAYS [MO_COUNT] = '{
      7'd31, 7'd28, 7'd31, 7'd30, 7'd31, 7'd30,
      7'd31, 7'd31, 7'd30, 7'd31, 7'd30, 7'd31
   };
   localparam logic [3:0] MO_FEB = 4'd1;

   // Day of a year that starts in March, for the first day of each month.
   localparam logic [8:0] DOY_START [MO_COUNT] = '{
      9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,
      9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
   };

   // Characters of the fixed text.
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_CASE  = 8'h20;
   localparam logic [7:0] CH_LC_G  = 8'h67;
   localparam logic [7:0] CH_LC_M  = 8'h6D;
   localparam logic [7:0] CH_LC_T  = 8'h74;

   // Year and time limits.
   localparam logic [13:0] YEAR_PIVOT = 14'd68;
   localparam logic [13:0] YEAR_BASE_20 = 14'd2000;
   localparam logic [13:0] YEAR_BASE_19 = 14'd1900;
   localparam logic [6:0]  HOUR_LIMIT = 7'd24;
   localparam logic [6:0]  MIN_LIMIT = 7'd60;

   // Calendar arithmetic.
   localparam logic [13:0] ERA_SHIFT = 14'd400;
   localparam logic [21:0] DAYS_PER_YEAR = 22'd365;
   localparam logic [12:0] RECIP_25 = 13'd5243;
   localparam int          RECIP_SHIFT = 17;
   localparam logic signed [23:0] EPOCH_DAYS = 24'sd865565;
   localparam logic [41:0] SECS_PER_DAY = 42'd86400;

   // Fields handed from the parser to the seconds calculation.
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } date_fields_type;

   // One result; date_ok lands in the lowest bit.
   typedef struct packed {
      logic signed [38:0] epoch_seconds;
      logic               date_ok;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic wd_char_hit(input int idx, input logic [3:0] pos,
                                        input logic [7:0] lc);
      logic hit;
      hit = 1'b0;
      if (pos < WD_LEN[idx]) begin
         hit = (WD_NAME[idx][8*(8-int'(pos)) +: 8] == lc);
      end
      return hit;
   endfunction

   function automatic logic mo_char_hit(input int idx, input logic [3:0] pos,
                                        input logic [7:0] lc);
      logic hit;
      hit = 1'b0;
      if (pos < 4'd3) begin
         hit = (MO_NAME[idx][8*(2-int'(pos)) +: 8] == lc);
      end
      return hit;
   endfunction

endpackage

FILE: sv/hdep_parse.sv
// ----------------------------------------------------------------------------
// HTTP date parser: character stage
// Updates the parse state with each accepted character and forms the result
// on the character marked last.
// ----------------------------------------------------------------------------
module hdep_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     char_take,
   input  logic [7:0]               char_code,
   input  logic                     is_last,
   input  logic signed [38:0]       epoch_seconds,
   output hdep_pkg::date_fields_type fields,
   output logic                     result_push,
   output hdep_pkg::result_type     result_item
);
   import hdep_pkg::*;

   phase_type   phase_ff, phase_in, cur;
   logic [6:0]  wd_cand_ff, wd_cand_in, wd_hit_v;
   logic [11:0] mo_cand_ff, mo_cand_in, mo_hit_v;
   logic [3:0]  name_pos_ff, name_pos_in;
   logic [6:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in, mo_pick;
   logic [13:0] year_ff, year_in;
   logic [2:0]  digit_cnt_ff, digit_cnt_in;
   logic [15:0] yr_dig_ff, yr_dig_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        failed_ff, failed_in;

   logic        take, busy, wd_done, dig, date_ok;
   logic [7:0]  lc;
   logic [3:0]  d;
   logic [6:0]  d7, tens_hour, tens_min, tens_sec, tens_day, mo_limit;
   logic [16:0] year_acc;
   logic [1:0]  lo_mod4, hi_mod4;
   logic        lo_zero, hi_div4, leap;

   // Character classes.
   assign lc  = ((char_code >= CH_UC_A) && (char_code <= CH_UC_Z)) ?
                (char_code | CH_CASE) : char_code;
   assign d   = char_code[3:0];
   assign d7  = {3'b000, d};
   assign dig = is_digit(char_code);
   assign take = char_take && !failed_ff;

   // Second-digit accumulation for two-digit fields.
   assign tens_day    = 7'((day_ff << 3) + (day_ff << 1)) + d7;
   assign tens_hour   = 7'((hour_ff << 3) + (hour_ff << 1)) + d7;
   assign tens_min    = 7'((minute_ff << 3) + (minute_ff << 1)) + d7;
   assign tens_sec    = 7'((second_ff << 3) + (second_ff << 1)) + d7;
   assign year_acc    = ({3'b000, year_ff} * 17'd10) + {13'b0, d};

   // Leap year from the year's digits: the last two digits and the century.
   assign lo_mod4 = {yr_dig_ff[4], 1'b0} + yr_dig_ff[1:0];
   assign hi_mod4 = {yr_dig_ff[12], 1'b0} + yr_dig_ff[9:8];
   assign lo_zero = (yr_dig_ff[7:0] == 8'h00);
   assign hi_div4 = (digit_cnt_ff == 3'd4) ? (hi_mod4 == 2'd0) : (year_ff <= YEAR_PIVOT);
   assign leap    = (lo_mod4 == 2'd0) && (!lo_zero || hi_div4);
   assign mo_limit = MO_DAYS[month_ff] + {6'b0, (month_ff == MO_FEB) && leap};

   // Name matching against the remaining weekday and month candidates.
   always_comb begin
      wd_hit_v = '0;
      mo_hit_v = '0;
      wd_done  = 1'b0;
      mo_pick  = month_ff;
      for (int i = 0; i < WD_COUNT; i++) begin
         wd_hit_v[i] = wd_cand_ff[i] && wd_char_hit(i, name_pos_ff, lc);
      end
      for (int i = 0; i < MO_COUNT; i++) begin
         mo_hit_v[i] = mo_cand_ff[i] && mo_char_hit(i, name_pos_ff, lc);
      end
      for (int i = 0; i < WD_COUNT; i++) begin
         if (wd_hit_v[i] && (({1'b0, name_pos_ff} + 5'd1) == {1'b0, WD_LEN[i]})) begin
            wd_done = 1'b1;
         end
      end
      for (int i = 0; i < MO_COUNT; i++) begin
         if (mo_hit_v[i]) begin
            mo_pick = 4'(i);
         end
      end
   end

   // Next parse state. Optional parts that do not match hand the same
   // character on to the comma, space and day fields.
   always_comb begin
      phase_in     = phase_ff;
      wd_cand_in   = wd_cand_ff;
      mo_cand_in   = mo_cand_ff;
      name_pos_in  = name_pos_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      digit_cnt_in = digit_cnt_ff;
      yr_dig_in    = yr_dig_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      failed_in    = failed_ff;
      cur          = phase_ff;
      busy         = 1'b0;

      if (take) begin
         busy = 1'b1;
         if (cur == PH_WDAY) begin
            if (wd_hit_v == '0) begin
               if (name_pos_ff == 4'd0 || name_pos_ff == 4'd3) begin
                  cur = PH_COMMA;
               end else begin
                  failed_in = 1'b1;
                  busy      = 1'b0;
               end
            end else begin
               wd_cand_in  = wd_hit_v;
               name_pos_in = name_pos_ff + 4'd1;
               if (wd_done) begin
                  phase_in = PH_COMMA;
               end
               busy = 1'b0;
            end
         end
         if (busy && cur == PH_COMMA) begin
            if (char_code == CH_COMMA) begin
               phase_in = PH_SPACE;
               busy     = 1'b0;
            end else begin
               cur = PH_SPACE;
            end
         end
         if (busy && cur == PH_SPACE) begin
            if (char_code == CH_SPACE) begin
               phase_in = PH_DAY1;
               busy     = 1'b0;
            end else begin
               cur = PH_DAY1;
            end
         end
         if (busy) begin
            unique case (cur)
               PH_DAY1: begin
                  if (!dig) failed_in = 1'b1;
                  else begin day_in = d7; phase_in = PH_DAY2; end
               end
               PH_DAY2: begin
                  if (!dig) failed_in = 1'b1;
                  else begin day_in = tens_day; phase_in = PH_DAYSEP; end
               end
               PH_DAYSEP: begin
                  if (char_code != CH_DASH && char_code != CH_SPACE) failed_in = 1'b1;
                  else begin
                     phase_in    = PH_MON;
                     name_pos_in = 4'd0;
                     mo_cand_in  = '1;
                  end
               end
               PH_MON: begin
                  if (mo_hit_v == '0) failed_in = 1'b1;
                  else begin
                     mo_cand_in  = mo_hit_v;
                     name_pos_in = name_pos_ff + 4'd1;
                     if (name_pos_ff >= 4'd2) begin
                        month_in = mo_pick;
                        phase_in = PH_MONSEP;
                     end
                  end
               end
               PH_MONSEP: begin
                  if (char_code != CH_DASH && char_code != CH_SPACE) failed_in = 1'b1;
                  else begin
                     phase_in     = PH_YEAR;
                     digit_cnt_in = 3'd0;
                     year_in      = 14'd0;
                  end
               end
               PH_YEAR: begin
                  if (dig && digit_cnt_ff < 3'd4) begin
                     year_in      = year_acc[13:0];
                     digit_cnt_in = digit_cnt_ff + 3'd1;
                     yr_dig_in    = {yr_dig_ff[11:0], d};
                  end else if (char_code == CH_SPACE &&
                               (digit_cnt_ff == 3'd2 || digit_cnt_ff == 3'd4)) begin
                     if (digit_cnt_ff == 3'd2) begin
                        year_in = year_ff + ((year_ff <= YEAR_PIVOT) ? YEAR_BASE_20
                                                                    : YEAR_BASE_19);
                     end
                     // The day is checked against the month length here.
                     if (day_ff == 7'd0 || day_ff > mo_limit) failed_in = 1'b1;
                     phase_in = PH_H1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_H1: begin
                  if (!dig) failed_in = 1'b1;
                  else begin hour_in = d7; phase_in = PH_H2; end
               end
               PH_H2: begin
                  if (!dig) failed_in = 1'b1;
                  else begin hour_in = tens_hour; phase_in = PH_C1; end
               end
               PH_C1: begin
                  if (char_code != CH_COLON) failed_in = 1'b1;
                  else phase_in = PH_M1;
               end
               PH_M1: begin
                  if (!dig) failed_in = 1'b1;
                  else begin minute_in = d7; phase_in = PH_M2; end
               end
               PH_M2: begin
                  if (!dig) failed_in = 1'b1;
                  else begin minute_in = tens_min; phase_in = PH_C2; end
               end
               PH_C2: begin
                  if (char_code != CH_COLON) failed_in = 1'b1;
                  else phase_in = PH_S1;
               end
               PH_S1: begin
                  if (!dig) failed_in = 1'b1;
                  else begin second_in = d7; phase_in = PH_S2; end
               end
               PH_S2: begin
                  if (!dig) failed_in = 1'b1;
                  else begin second_in = tens_sec; phase_in = PH_SP; end
               end
               PH_SP: begin
                  if (char_code != CH_SPACE || hour_ff >= HOUR_LIMIT ||
                      minute_ff >= MIN_LIMIT || second_ff >= MIN_LIMIT) begin
                     failed_in = 1'b1;
                  end else begin
                     phase_in = PH_G;
                  end
               end
               PH_G: begin
                  if (lc != CH_LC_G) failed_in = 1'b1;
                  else phase_in = PH_GM;
               end
               PH_GM: begin
                  if (lc != CH_LC_M) failed_in = 1'b1;
                  else phase_in = PH_GMT;
               end
               PH_GMT: begin
                  if (lc != CH_LC_T) failed_in = 1'b1;
                  else phase_in = PH_DONE;
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end

      // The result is judged on the state after the last character.
      date_ok = !failed_in && (phase_in == PH_DONE);

      // A finished text returns the parser to its reset state.
      if (char_take && is_last) begin
         phase_in     = PH_WDAY;
         wd_cand_in   = '1;
         mo_cand_in   = '1;
         name_pos_in  = 4'd0;
         day_in       = 7'd0;
         month_in     = 4'd0;
         year_in      = 14'd0;
         digit_cnt_in = 3'd0;
         yr_dig_in    = 16'd0;
         hour_in      = 7'd0;
         minute_in    = 7'd0;
         second_in    = 7'd0;
         failed_in    = 1'b0;
      end
   end

   assign result_push               = char_take && is_last;
   assign result_item.date_ok       = date_ok;
   assign result_item.epoch_seconds = date_ok ? epoch_seconds : '0;

   assign fields.year   = year_ff;
   assign fields.month  = month_ff;
   assign fields.day    = day_ff;
   assign fields.hour   = hour_ff;
   assign fields.minute = minute_ff;
   assign fields.second = second_ff;

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WDAY;
         wd_cand_ff   <= '1;
         mo_cand_ff   <= '1;
         name_pos_ff  <= 4'd0;
         day_ff       <= 7'd0;
         month_ff     <= 4'd0;
         year_ff      <= 14'd0;
         digit_cnt_ff <= 3'd0;
         yr_dig_ff    <= 16'd0;
         hour_ff      <= 7'd0;
         minute_ff    <= 7'd0;
         second_ff    <= 7'd0;
         failed_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wd_cand_ff   <= wd_cand_in;
         mo_cand_ff   <= mo_cand_in;
         name_pos_ff  <= name_pos_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         digit_cnt_ff <= digit_cnt_in;
         yr_dig_ff    <= yr_dig_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         failed_ff    <= failed_in;
      end
   end

endmodule

FILE: sv/hdep_epoch.sv
// ----------------------------------------------------------------------------
// HTTP date parser: seconds calculation
// Three-stage pipeline that turns the parsed date fields into seconds since
// 1970-01-01 GMT. It runs every cycle on the current parse state.
// ----------------------------------------------------------------------------
module hdep_epoch (
   input  logic                      clock,
   input  hdep_pkg::date_fields_type fields,
   output logic signed [38:0]        epoch_seconds
);
   import hdep_pkg::*;

   logic [13:0] yy;
   logic        early_month;

   logic [21:0] a_yy365_ff;
   logic [11:0] a_q4_ff;
   logic [24:0] a_p100_ff;
   logic [22:0] a_p400_ff;
   logic [9:0]  a_doy_ff;
   logic [18:0] a_hms_ff;

   logic [22:0]        b_sum;
   logic signed [23:0] b_days_ff;
   logic [18:0]        b_hms_ff;

   logic [41:0]        c_total;
   logic signed [38:0] c_epoch_ff;

   // January and February count in the previous March-based year.
   assign early_month = (fields.month <= 4'd1);
   assign yy = fields.year + ERA_SHIFT - {13'b0, early_month};

   // Stage A: year products, divide-by-25 reciprocals, day of year, time.
   always_ff @(posedge clock) begin
      a_yy365_ff <= {8'b0, yy} * DAYS_PER_YEAR;
      a_q4_ff    <= yy[13:2];
      a_p100_ff  <= {13'b0, yy[13:2]} * {12'b0, RECIP_25};
      a_p400_ff  <= {13'b0, yy[13:4]} * {10'b0, RECIP_25};
      a_doy_ff   <= {1'b0, DOY_START[fields.month]} + {3'b0, fields.day} - 10'd1;
      a_hms_ff   <= ({12'b0, fields.hour} * 19'd3600) + ({12'b0, fields.minute} * 19'd60)
                    + {12'b0, fields.second};
   end

   // Stage B: day count relative to 1970-01-01.
   assign b_sum = {1'b0, a_yy365_ff} + {11'b0, a_q4_ff}
                  - {15'b0, a_p100_ff[24:RECIP_SHIFT]}
                  + {17'b0, a_p400_ff[22:RECIP_SHIFT]} + {13'b0, a_doy_ff};

   always_ff @(posedge clock) begin
      b_days_ff <= $signed({1'b0, b_sum}) - EPOCH_DAYS;
      b_hms_ff  <= a_hms_ff;
   end

   // Stage C: days to seconds plus the time of day.
   assign c_total = (42'(b_days_ff) * SECS_PER_DAY) + {23'b0, b_hms_ff};

   always_ff @(posedge clock) begin
      c_epoch_ff <= $signed(c_total[38:0]);
   end

   assign epoch_seconds = c_epoch_ff;

endmodule

FILE: sv/hdep_outbuf.sv
// ----------------------------------------------------------------------------
// HTTP date parser: result buffer
// Output register with a skid entry, so the input side keeps taking
// characters while a result waits for the receiver.
// ----------------------------------------------------------------------------
module hdep_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hdep_pkg::result_type push_item,
   input  logic                 pop_ready,
   output logic                 out_valid,
   output hdep_pkg::result_type out_item,
   output logic                 in_ready
);
   import hdep_pkg::*;

   logic       main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   result_type main_ff, main_in, skid_ff, skid_in;
   logic       pop;

   assign pop = main_v_ff && pop_ready;

   // Refill the output register from the skid entry first, then from a new result.
   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!main_v_ff || pop) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = push;
            main_in   = push_item;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_item  = main_ff;
   assign in_ready  = !skid_v_ff;

endmodule

FILE: sv/http_date_to_epoch_parser.sv
// ----------------------------------------------------------------------------
// HTTP date parser top level
// Checks an HTTP date text and converts it to seconds since 1970 GMT.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries the date text one character per transfer, with
//   req_tlast on the final character. Every transfer updates the parse state;
//   only the final one produces a result on the rsp channel: date_ok and the
//   signed seconds since 1970-01-01 GMT (zero when the text is not a valid
//   GMT date).
//   One character is taken per cycle while req_tready is high. The result is
//   registered when the final character is accepted. The seconds are computed
//   by a three-stage pipeline running on the parse state, which has settled by
//   the time the closing "GMT" has been read.
//   When the receiver stalls, the result waits in the output register and
//   characters keep flowing; a second result goes to a skid entry, and
//   req_tready drops only while that entry is occupied.
//   Reset clears the parse state and drops any pending result; the parser then
//   expects the start of a new text.
// ----------------------------------------------------------------------------
module http_date_to_epoch_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] date_ok, [39:1] epoch_seconds
);
   import hdep_pkg::*;

   logic               req_accept;
   logic               result_push;
   result_type         result_item;
   result_type         out_item;
   date_fields_type    fields;
   logic signed [38:0] epoch_seconds;

   assign req_accept = req_tvalid && req_tready;

   // Character parser.
   hdep_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .char_take     (req_accept),
      .char_code     (req_tdata),
      .is_last       (req_tlast),
      .epoch_seconds (epoch_seconds),
      .fields        (fields),
      .result_push   (result_push),
      .result_item   (result_item)
   );

   // Seconds calculation pipeline.
   hdep_epoch u_epoch (
      .clock         (clock),
      .fields        (fields),
      .epoch_seconds (epoch_seconds)
   );

   // Result register with skid entry.
   hdep_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_item (result_item),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .in_ready  (req_tready)
   );

   assign rsp_tdata = out_item;

`ifndef NO_ASSERTIONS
   // A final character always leaves a result ready in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("result missing after final character");

   // Back-pressure on the input only happens with a result already waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // An invalid date carries zero seconds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[39:1] == 39'd0)
      else $error("nonzero seconds on invalid date");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

FILE: test/http_date_to_epoch_parser_tb.sv
// ----------------------------------------------------------------------------
// HTTP date parser testbench
// Streams date texts one character per transfer into the parser and checks
// every result against a behavioral predictor that runs in the testbench.
// Directed texts cover date extremes, weekday forms and malformed input.
// Random texts are mostly well-formed dates with random content and case,
// mixed with damaged texts and noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module http_date_to_epoch_parser_tb;
   import hdep_pkg::*;

   localparam int RANDOM_CHARS    = 350;
   localparam int RANDOM_TEXTS    = 12;
   localparam int RUN_LIMIT       = 800000;
   localparam int DRAIN_CYCLES    = 10;

   typedef logic [7:0] text_type [$];

   // Clock, reset and the ports of the block
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_code
   logic        req_tlast = 1'b0;    // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [0] date_ok, [39:1] epoch_seconds

   // Idling switches for the sender and the receiver
   logic req_idle = 1'b0;
   logic rsp_idle = 1'b0;

   // Run statistics
   int error_count   = 0;
   int chars_sent    = 0;
   int texts_sent    = 0;
   int results_seen  = 0;
   int valid_seen    = 0;

   // Name tables and calendar data used by the predictor and the generator
   string weekday_names [7] = '{"sunday", "monday", "tuesday", "wednesday",
                                "thursday", "friday", "saturday"};
   string month_names [12] = '{"jan", "feb", "mar", "apr", "may", "jun",
                               "jul", "aug", "sep", "oct", "nov", "dec"};
   int    month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   int    year_corners [9] = '{0, 1900, 1968, 1969, 1970, 2000, 2100, 2400, 9999};

   // Parse state of the predictor
   phase_type    parse_phase;
   logic [6:0]   weekday_hits_left;
   logic [11:0]  month_hits_left;
   logic [3:0]   name_pos;
   logic [6:0]   day_num;
   logic [3:0]   month_num;
   logic [13:0]  year_num;
   logic [2:0]   year_digits;
   logic [6:0]   hour_num;
   logic [6:0]   minute_num;
   logic [6:0]   second_num;
   logic         text_bad;

   // Dates still waiting for their result transfer, oldest first
   result_type expected_results [$];

   http_date_to_epoch_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Gregorian leap year rule.
   function automatic logic leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // Number of days in a zero-based month of the given year.
   function automatic int month_length(input int m, input int y);
      if (m == 1 && leap_year(y)) begin
         return 29;
      end
      return month_days[m];
   endfunction

   // Back to the start of a new text.
   function automatic void clear_parse_state();
      parse_phase       = PH_WDAY;
      weekday_hits_left = '1;
      month_hits_left   = '1;
      name_pos          = '0;
      day_num           = '0;
      month_num         = '0;
      year_num          = '0;
      year_digits       = '0;
      hour_num          = '0;
      minute_num        = '0;
      second_num        = '0;
      text_bad          = 1'b0;
   endfunction

   // Advances the date parse by one character; on the last one it queues the
   // expected date_ok and seconds since 1970 and starts over.
   function automatic void predict_char(input logic [7:0] c, input logic last);
      logic [7:0]  lc;
      logic [3:0]  dv;
      logic        numeric;
      logic        retry;
      logic [6:0]  wd_hit;
      logic [11:0] mo_hit;
      longint      yr, yy, era, yoe, mp, doy, days, secs_total;
      result_type  want;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      dv = c[3:0];
      numeric = (c >= "0") && (c <= "9");
      retry = !text_bad;
      while (retry) begin
         retry = 1'b0;
         case (parse_phase)
            PH_WDAY: begin
               wd_hit = '0;
               for (int i = 0; i < 7; i++) begin
                  if (weekday_hits_left[i] && name_pos < weekday_names[i].len() &&
                      weekday_names[i][name_pos] == lc) begin
                     wd_hit[i] = 1'b1;
                  end
               end
               if (wd_hit == '0) begin
                  // No weekday at all, or a bare three-letter prefix: fall through.
                  if (name_pos == 0 || name_pos == 3) begin
                     parse_phase = PH_COMMA;
                     retry = 1'b1;
                  end else begin
                     text_bad = 1'b1;
                  end
               end else begin
                  weekday_hits_left = wd_hit;
                  name_pos++;
                  for (int i = 0; i < 7; i++) begin
                     if (wd_hit[i] && name_pos == weekday_names[i].len()) begin
                        parse_phase = PH_COMMA;
                     end
                  end
               end
            end
            PH_COMMA: begin
               parse_phase = PH_SPACE;
               retry = (c != ",");
            end
            PH_SPACE: begin
               parse_phase = PH_DAY1;
               retry = (c != " ");
            end
            PH_DAY1: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  day_num = {3'b000, dv};
                  parse_phase = PH_DAY2;
               end
            end
            PH_DAY2: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  day_num = day_num * 7'd10 + dv;
                  parse_phase = PH_DAYSEP;
               end
            end
            PH_DAYSEP: begin
               if (c != "-" && c != " ") text_bad = 1'b1;
               else begin
                  parse_phase = PH_MON;
                  name_pos = '0;
                  month_hits_left = '1;
               end
            end
            PH_MON: begin
               mo_hit = '0;
               for (int i = 0; i < 12; i++) begin
                  if (month_hits_left[i] && name_pos < 3 &&
                      month_names[i][name_pos] == lc) begin
                     mo_hit[i] = 1'b1;
                  end
               end
               if (mo_hit == '0) text_bad = 1'b1;
               else begin
                  month_hits_left = mo_hit;
                  name_pos++;
                  if (name_pos >= 3) begin
                     for (int i = 0; i < 12; i++) begin
                        if (mo_hit[i]) month_num = 4'(i);
                     end
                     parse_phase = PH_MONSEP;
                  end
               end
            end
            PH_MONSEP: begin
               if (c != "-" && c != " ") text_bad = 1'b1;
               else begin
                  parse_phase = PH_YEAR;
                  year_digits = '0;
                  year_num = '0;
               end
            end
            PH_YEAR: begin
               if (numeric && year_digits < 4) begin
                  year_num = year_num * 14'd10 + dv;
                  year_digits++;
               end else if (c == " " && (year_digits == 2 || year_digits == 4)) begin
                  // Two-digit years pivot at 68; the day is checked once the year is known.
                  if (year_digits == 2) begin
                     year_num = year_num + ((year_num <= 68) ? 14'd2000 : 14'd1900);
                  end
                  if (day_num == 0 || day_num > month_length(month_num, year_num)) begin
                     text_bad = 1'b1;
                  end
                  parse_phase = PH_H1;
               end else begin
                  text_bad = 1'b1;
               end
            end
            PH_H1: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  hour_num = {3'b000, dv};
                  parse_phase = PH_H2;
               end
            end
            PH_H2: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  hour_num = hour_num * 7'd10 + dv;
                  parse_phase = PH_C1;
               end
            end
            PH_C1: begin
               if (c != ":") text_bad = 1'b1;
               else parse_phase = PH_M1;
            end
            PH_M1: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  minute_num = {3'b000, dv};
                  parse_phase = PH_M2;
               end
            end
            PH_M2: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  minute_num = minute_num * 7'd10 + dv;
                  parse_phase = PH_C2;
               end
            end
            PH_C2: begin
               if (c != ":") text_bad = 1'b1;
               else parse_phase = PH_S1;
            end
            PH_S1: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  second_num = {3'b000, dv};
                  parse_phase = PH_S2;
               end
            end
            PH_S2: begin
               if (!numeric) text_bad = 1'b1;
               else begin
                  second_num = second_num * 7'd10 + dv;
                  parse_phase = PH_SP;
               end
            end
            PH_SP: begin
               if (c != " " || hour_num >= 24 || minute_num >= 60 || second_num >= 60) begin
                  text_bad = 1'b1;
               end else begin
                  parse_phase = PH_G;
               end
            end
            PH_G: begin
               if (lc != "g") text_bad = 1'b1;
               else parse_phase = PH_GM;
            end
            PH_GM: begin
               if (lc != "m") text_bad = 1'b1;
               else parse_phase = PH_GMT;
            end
            PH_GMT: begin
               if (lc != "t") text_bad = 1'b1;
               else parse_phase = PH_DONE;
            end
            default: begin
               // Anything after the closing GMT spoils the text.
               text_bad = 1'b1;
            end
         endcase
      end
      if (last) begin
         want.date_ok = !text_bad && (parse_phase == PH_DONE);
         want.epoch_seconds = '0;
         if (want.date_ok) begin
            // Day count from a March-based year, shifted by one 400-year era.
            yr   = longint'(year_num);
            yy   = yr + 400 - ((month_num < 2) ? 1 : 0);
            era  = yy / 400;
            yoe  = yy - era * 400;
            mp   = (longint'(month_num) + 10) % 12;
            doy  = (153 * mp + 2) / 5 + longint'(day_num) - 1;
            days = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468 - 146097;
            secs_total = days * 86400 + longint'(hour_num) * 3600 +
                         longint'(minute_num) * 60 + longint'(second_num);
            want.epoch_seconds = secs_total[38:0];
         end
         expected_results.push_back(want);
         clear_parse_state();
      end
   endfunction

   // Wait before an item or a result: none while idling is off.
   function automatic int pick_wait(input logic enabled);
      return enabled ? int'($urandom_range(0, 16)) : 0;
   endfunction

   function automatic text_type to_text(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) begin
         t.push_back(s[i]);
      end
      return t;
   endfunction

   // Appends a name with each letter in random case.
   function automatic void push_word(ref text_type t, input string w);
      logic [7:0] ch;
      for (int i = 0; i < w.len(); i++) begin
         ch = w[i];
         if ($urandom_range(0, 1) && ch >= "a" && ch <= "z") begin
            ch = ch - 8'd32;
         end
         t.push_back(ch);
      end
   endfunction

   // Appends a decimal number with exactly n digits.
   function automatic void push_num(ref text_type t, input int v, input int n);
      int p;
      p = 1;
      repeat (n - 1) p = p * 10;
      while (p > 0) begin
         t.push_back(8'("0" + (v / p) % 10));
         p = p / 10;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // One character transfer; the predictor sees it at its accepting edge.
   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = pick_wait(req_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      predict_char(ch, last);
   endtask

   task automatic send_text(input text_type t);
      for (int i = 0; i < t.size(); i++) begin
         send_char(t[i], i == t.size() - 1);
      end
      texts_sent++;
   endtask

   // Mostly well-formed dates, including the earliest and latest representable ones.
   task automatic test_valid_dates();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      send_text(to_text("Thu, 01 Jan 1970 00:00:00 GMT"));
      send_text(to_text("Sun, 06 Nov 1994 08:49:37 GMT"));
      send_text(to_text("Sunday, 06-Nov-94 08:49:37 GMT"));
      send_text(to_text("01 Jan 0000 00:00:00 GMT"));
      send_text(to_text("Fri, 31 Dec 9999 23:59:59 GMT"));
      send_text(to_text("wEdNeSdAy 29-feb-2000 12:00:00 gmt"));
      send_text(to_text("29 Feb 1900 00:00:00 GMT"));
      send_text(to_text("Tue,31 Dec 68 23:59:59 GMT"));
      send_text(to_text("01 Jan 69 00:00:00 GMT"));
      send_text(to_text("29 Feb 00 00:00:00 GMT"));
   endtask

   // Short, partial and misspelt weekday names.
   task automatic test_weekday_forms();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_text(to_text("Sundx, 06 Nov 1994 08:49:37 GMT"));
      send_text(to_text("Thurs, 01 Jan 1970 00:00:00 GMT"));
      send_text(to_text("S, 01 Jan 1970 00:00:00 GMT"));
      send_text(to_text("SAT 01 Jan 2000 00:00:00 GMT"));
   endtask

   // Bad years, early or late endings, a zero byte, out-of-range values and a bad month.
   task automatic test_malformed_texts();
      text_type t;
      send_text(to_text("01 Jan 199 00:00:00 GMT"));
      send_text(to_text("01 Jan 19999 00:00:00 GMT"));
      send_text(to_text("01 Jan 2000 00:00:00 GM"));
      send_text(to_text("01 Jan 2000 00:00:00 GMTX"));
      t = to_text("01 Jan 2000 00:00:00 GMT");
      t.insert(3, 8'h00);
      send_text(t);
      send_text(to_text("00 Jan 2000 00:00:00 GMT"));
      send_text(to_text("31 Apr 2000 00:00:00 GMT"));
      send_text(to_text("01 Jan 2000 24:00:00 GMT"));
      send_text(to_text("01 Jan 2000 23:60:00 GMT"));
      send_text(to_text("01 Jan 2000 23:59:60 GMT"));
      send_text(to_text("01 Jab 2000 00:00:00 GMT"));
      send_text(to_text("X"));
   endtask

   // Mostly well-formed dates with random content, some damaged, some noise.
   task automatic test_random_texts();
      text_type t;
      int texts_done, start_chars, kind, pos, yr, full_yr, ydig, mon, dd;
      texts_done = 0;
      start_chars = chars_sent;
      while (chars_sent - start_chars < RANDOM_CHARS || texts_done < RANDOM_TEXTS) begin
         // Change the idling of both sides every few texts.
         if (texts_done % 3 == 0) begin
            req_idle = ($urandom_range(0, 3) != 0);
            rsp_idle = ($urandom_range(0, 3) != 0);
         end
         t.delete();
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 10)) t.push_back(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 2))
               1: push_word(t, weekday_names[$urandom_range(0, 6)].substr(0, 2));
               2: push_word(t, weekday_names[$urandom_range(0, 6)]);
               default: ;
            endcase
            if ($urandom_range(0, 3) != 0) t.push_back(",");
            if ($urandom_range(0, 3) != 0) t.push_back(" ");
            mon = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) begin
               yr = $urandom_range(0, 99);
               full_yr = (yr <= 68) ? 2000 + yr : 1900 + yr;
               ydig = 2;
            end else begin
               yr = ($urandom_range(0, 2) == 0) ? year_corners[$urandom_range(0, 8)]
                                                : int'($urandom_range(0, 9999));
               full_yr = yr;
               ydig = 4;
            end
            case ($urandom_range(0, 7))
               0: dd = $urandom_range(0, 99);
               1: dd = month_length(mon, full_yr) + $urandom_range(0, 1);
               default: dd = $urandom_range(1, month_length(mon, full_yr));
            endcase
            push_num(t, dd, 2);
            t.push_back($urandom_range(0, 1) ? "-" : " ");
            push_word(t, month_names[mon]);
            t.push_back($urandom_range(0, 1) ? "-" : " ");
            push_num(t, yr, ydig);
            t.push_back(" ");
            push_num(t, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                    : $urandom_range(0, 23), 2);
            t.push_back(":");
            push_num(t, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                    : $urandom_range(0, 59), 2);
            t.push_back(":");
            push_num(t, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                    : $urandom_range(0, 59), 2);
            t.push_back(" ");
            push_word(t, "gmt");
            // Damage some of the dates at a random spot.
            pos = $urandom_range(0, t.size() - 1);
            case (kind)
               1: t[pos] = 8'($urandom_range(0, 255));
               2: begin
                  if ($urandom_range(0, 1)) begin
                     while (t.size() > pos + 1) void'(t.pop_back());
                  end else begin
                     t.push_back(8'($urandom_range(0, 255)));
                  end
               end
               3: begin
                  if ($urandom_range(0, 1)) t.delete(pos);
                  else t.insert(pos, 8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
         end
         send_text(t);
         texts_done++;
      end
   endtask

   // Result receiver with random stalls.
   initial begin : result_receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_wait(rsp_idle);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare every result transfer with the oldest expected date.
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no date pending: %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            results_seen++;
            if (want.date_ok) valid_seen++;
            if (got.date_ok !== want.date_ok) begin
               report_mismatch($sformatf("result %0d date_ok %b, expected %b",
                                         results_seen, got.date_ok, want.date_ok));
            end
            if (got.epoch_seconds !== want.epoch_seconds) begin
               report_mismatch($sformatf("result %0d epoch_seconds %0d, expected %0d",
                                         results_seen, got.epoch_seconds,
                                         want.epoch_seconds));
            end
         end
      end
   end

   // Main sequence.
   initial begin
      clear_parse_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_valid_dates();
      test_weekday_forms();
      test_malformed_texts();
      test_random_texts();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d date texts in %0d character transfers.", texts_sent, chars_sent);
      $display("Checked %0d results, %0d of them valid dates, %0d mismatches.",
               results_seen, valid_seen, error_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog in case a handshake never completes.
   initial begin
      #RUN_LIMIT;
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/hdep_pkg.sv
sv/hdep_parse.sv
sv/hdep_epoch.sv
sv/hdep_outbuf.sv
sv/http_date_to_epoch_parser.sv
test/http_date_to_epoch_parser_tb.sv
